// ===== sv/mbq_pkg.sv =====
// Package for the mailbox queue store: sizes, request and status codes, and the
// command and status structs that join the controller and the datapath.
// No dependencies.
package mbq_pkg;

  localparam int NUM_BOXES   = 1024;
  localparam int QUEUE_DEPTH = 3;
  localparam int WORD_WIDTH  = 64;

  // Fixed field widths of the stream payloads.
  localparam int REQ_W      = 2;
  localparam int BOX_ID_W   = 10;
  localparam int MSG_W      = 64;
  localparam int STATUS_W   = 2;
  localparam int DATA_W     = 64;
  localparam int IN_TDATA_W = 80;
  localparam int OUT_TDATA_W = 72;

  // Derived storage widths.
  localparam int BOX_AW = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
  localparam int POS_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int RING_W = $clog2(2 * QUEUE_DEPTH);

  localparam logic [REQ_W-1:0] REQ_REG_QUEUED   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REG_UNQUEUED = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEND         = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RECV         = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAIL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DATA = 2'd2;

  typedef struct packed {
    logic              mode;
    logic              registered;
    logic [CNT_W-1:0]  count;
    logic [POS_W-1:0]  head;
  } box_state_t;

  typedef struct packed {
    logic              capture;
    logic              exec;
    logic              clr_we;
    logic [BOX_AW-1:0] clr_addr;
  } mbq_cmd_t;

  typedef struct packed {
    logic out_full;
  } mbq_stat_t;

endpackage

// ===== sv/mbq_ctrl.sv =====
// Controller of the mailbox queue store: clearing pass after reset, accept and
// execute sequencing, output register handshake.
// Depends on mbq_pkg.
module mbq_ctrl
  import mbq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  input  logic      m_axis_tready,
  input  mbq_stat_t stat_i,
  output mbq_cmd_t  cmd_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [BOX_AW-1:0] clr_addr_q, clr_addr_d;
  logic              accept;
  logic              exec;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  // The result may only be loaded once the output register is free or being emptied.
  assign exec          = (state_q == S_EXEC) && (!stat_i.out_full || m_axis_tready);

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    case (state_q)
      S_CLEAR: begin
        clr_addr_d = clr_addr_q + BOX_AW'(1);
        if (clr_addr_q == BOX_AW'(NUM_BOXES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign cmd_o.capture  = accept;
  assign cmd_o.exec     = exec;
  assign cmd_o.clr_we   = (state_q == S_CLEAR);
  assign cmd_o.clr_addr = clr_addr_q;

endmodule

// ===== sv/mbq_dp.sv =====
// Datapath of the mailbox queue store: per-box state memory, message slot
// memory, request evaluation and the output register.
// Depends on mbq_pkg.
module mbq_dp
  import mbq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tready,
  output logic                   m_axis_tvalid,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  mbq_cmd_t               cmd_i,
  output mbq_stat_t              stat_o
);

  box_state_t                         st_mem [NUM_BOXES];
  logic [QUEUE_DEPTH-1:0][WORD_WIDTH-1:0] slot_mem [NUM_BOXES];

  box_state_t                         st_rd_q;
  logic [QUEUE_DEPTH-1:0][WORD_WIDTH-1:0] row_rd_q;
  logic [REQ_W-1:0]                   req_q;
  logic [BOX_AW-1:0]                  box_q;
  logic                               range_q;
  logic [WORD_WIDTH-1:0]              word_q;

  logic [BOX_ID_W-1:0]   in_box;
  logic [BOX_AW-1:0]     in_addr;

  box_state_t            st_nxt;
  logic                  st_upd;
  logic [QUEUE_DEPTH-1:0] slot_we;
  logic [POS_W-1:0]      wpos;
  logic [STATUS_W-1:0]   res_status;
  logic [WORD_WIDTH-1:0] res_data;

  logic                  st_we;
  logic [BOX_AW-1:0]     st_waddr;
  box_state_t            st_wdata;

  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q;
  logic [DATA_W-1:0]     out_data_q;

  // Ring position head + off; the sum stays below twice the depth.
  function automatic logic [POS_W-1:0] ring_add(logic [POS_W-1:0] head,
                                                logic [CNT_W-1:0] off);
    logic [RING_W:0] sum;
    sum = (RING_W+1)'(head) + (RING_W+1)'(off);
    if (sum >= (RING_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (RING_W+1)'(QUEUE_DEPTH);
    end
    return POS_W'(sum);
  endfunction

  assign in_box  = s_axis_tdata[REQ_W +: BOX_ID_W];
  assign in_addr = BOX_AW'(in_box);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q    <= s_axis_tdata[REQ_W-1:0];
      box_q    <= in_addr;
      range_q  <= (32'(in_box) < NUM_BOXES);
      word_q   <= s_axis_tdata[REQ_W + BOX_ID_W +: WORD_WIDTH];
      st_rd_q  <= st_mem[in_addr];
      row_rd_q <= slot_mem[in_addr];
    end
  end

  always_comb begin
    st_nxt     = st_rd_q;
    st_upd     = 1'b0;
    slot_we    = '0;
    wpos       = st_rd_q.head;
    res_status = ST_FAIL;
    res_data   = '0;
    if (range_q) begin
      case (req_q)
        REQ_REG_QUEUED, REQ_REG_UNQUEUED: begin
          // The mode is taken even when the box is already registered.
          st_nxt.mode = (req_q == REQ_REG_UNQUEUED);
          st_upd      = 1'b1;
          if (!st_rd_q.registered) begin
            st_nxt.registered = 1'b1;
            res_status        = ST_OK;
          end
        end
        REQ_SEND: begin
          if (32'(st_rd_q.count) < QUEUE_DEPTH) begin
            st_upd     = 1'b1;
            res_status = ST_OK;
            if (st_rd_q.count == '0 || st_rd_q.mode) begin
              wpos         = st_rd_q.head;
              st_nxt.count = CNT_W'(1);
            end else begin
              wpos         = ring_add(st_rd_q.head, st_rd_q.count);
              st_nxt.count = st_rd_q.count + CNT_W'(1);
            end
            slot_we[wpos] = 1'b1;
          end
        end
        REQ_RECV: begin
          if (st_rd_q.count != '0) begin
            res_status = ST_DATA;
            res_data   = row_rd_q[st_rd_q.head];
            if (!st_rd_q.mode) begin
              st_upd       = 1'b1;
              st_nxt.head  = ring_add(st_rd_q.head, CNT_W'(1));
              st_nxt.count = st_rd_q.count - CNT_W'(1);
            end
          end
        end
        default: begin
          res_status = ST_FAIL;
        end
      endcase
    end
  end

  // The clearing pass and request updates share the state memory write port.
  assign st_we    = cmd_i.clr_we || (cmd_i.exec && st_upd);
  assign st_waddr = cmd_i.clr_we ? cmd_i.clr_addr : box_q;
  assign st_wdata = cmd_i.clr_we ? box_state_t'('0) : st_nxt;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < QUEUE_DEPTH; s++) begin
      if (cmd_i.exec && slot_we[s]) begin
        slot_mem[box_q][s] <= word_q;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_status_q <= res_status;
      out_data_q   <= DATA_W'(res_data);
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {(OUT_TDATA_W - DATA_W - STATUS_W)'(0), out_data_q, out_status_q};
  assign stat_o.out_full = out_valid_q;

endmodule

// ===== sv/mailbox_queue_store.sv =====
// Mailbox queue store: an array of mailboxes, each with a mode, a registered
// flag and a ring of message words.
// Depends on mbq_pkg, mbq_ctrl and mbq_dp.
//
// Requests enter on the slave stream, one transaction per request; tdata holds
// req_type, box_id and msg_word. Each request yields exactly one result
// transaction on the master stream, whose tdata holds status and data_word.
// A request is read when it is accepted: the box state and its message row are
// captured in registers. It is then evaluated and written back, loading the
// output register. The block takes no new request until the previous one has
// been evaluated, because of the read-modify-write of the per-box state memory.
// After reset the block clears the state memory, one box per cycle, over all
// NUM_BOXES boxes (1024), and holds s_axis_tready low meanwhile. Message
// words need no clearing. When the receiver stalls, one finished result waits
// in the output register while the next request is still accepted and read;
// its write-back waits until the output register is free.
module mailbox_queue_store
  import mbq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0: req_type[1:0], box_id[11:2], msg_word[75:12], zero pad.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0: status[1:0], data_word[65:2], zero pad.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  mbq_cmd_t  cmd;
  mbq_stat_t stat;

  mbq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tready (m_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  mbq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

  // A result is only loaded when the output register is free or being drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a pending output transaction");

  // Each accepted request is followed by a cycle without acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted back to back");

  // A new result only appears after an evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.exec))
    else $error("output valid without an evaluated request");

  // The status code is always one of the defined codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[STATUS_W-1:0] == ST_OK ||
                       m_axis_tdata[STATUS_W-1:0] == ST_FAIL ||
                       m_axis_tdata[STATUS_W-1:0] == ST_DATA))
    else $error("undefined status code on output");

  // The clearing pass and request evaluation never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_we |-> (!cmd.exec && !cmd.capture))
    else $error("request handled during clearing pass");

endmodule

// ===== sim/mbq_checker.sv =====
// Scoreboard for the mailbox queue store: watches both stream channels, keeps its
// own copy of the box state and compares every result with the predicted one.
// Depends on mbq_pkg.
module mbq_checker
  import mbq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data;
  } mbq_reply_t;

  bit                    box_unqueued [NUM_BOXES];
  bit                    box_claimed  [NUM_BOXES];
  int                    box_held     [NUM_BOXES];
  int                    box_oldest   [NUM_BOXES];
  logic [WORD_WIDTH-1:0] box_words    [NUM_BOXES][QUEUE_DEPTH];

  mbq_reply_t expected_replies[$];
  int         mismatches = 0;

  assign fail_count_o = mismatches;

  // Applies one request to the mirrored box state and returns its reply.
  function automatic mbq_reply_t serve_request(input logic [REQ_W-1:0]    req,
                                               input logic [BOX_ID_W-1:0] box,
                                               input logic [MSG_W-1:0]    word);
    mbq_reply_t r;
    int         b;
    int         cnt;
    int         hd;
    r.status = ST_FAIL;
    r.data   = '0;
    if (box < NUM_BOXES) begin
      b   = box;
      cnt = box_held[b];
      hd  = box_oldest[b];
      case (req)
        REQ_REG_QUEUED, REQ_REG_UNQUEUED: begin
          // The mode sticks even when the registration is refused.
          box_unqueued[b] = (req == REQ_REG_UNQUEUED);
          if (!box_claimed[b]) begin
            box_claimed[b] = 1'b1;
            r.status       = ST_OK;
          end
        end
        REQ_SEND: begin
          if (cnt < QUEUE_DEPTH) begin
            if (cnt == 0 || box_unqueued[b]) begin
              box_words[b][hd] = word[WORD_WIDTH-1:0];
              box_held[b]      = 1;
            end else begin
              box_words[b][(hd + cnt) % QUEUE_DEPTH] = word[WORD_WIDTH-1:0];
              box_held[b]                            = cnt + 1;
            end
            r.status = ST_OK;
          end
        end
        default: begin
          if (cnt != 0) begin
            r.status = ST_DATA;
            r.data   = DATA_W'(box_words[b][hd]);
            if (!box_unqueued[b]) begin
              box_oldest[b] = (hd + 1) % QUEUE_DEPTH;
              box_held[b]   = cnt - 1;
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mbq_reply_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BOXES; i++) begin
        box_unqueued[i] = 1'b0;
        box_claimed[i]  = 1'b0;
        box_held[i]     = 0;
        box_oldest[i]   = 0;
      end
      expected_replies.delete();
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_replies.size() == 0) begin
          $error("result transaction with no request outstanding: tdata %h", m_tdata_i);
          mismatches++;
        end else begin
          exp_r = expected_replies.pop_front();
          if (m_tdata_i[STATUS_W-1:0] !== exp_r.status) begin
            $error("status mismatch: expected %0d, got %0d",
                   exp_r.status, m_tdata_i[STATUS_W-1:0]);
            mismatches++;
          end
          if (m_tdata_i[STATUS_W +: DATA_W] !== exp_r.data) begin
            $error("data_word mismatch: expected %h, got %h",
                   exp_r.data, m_tdata_i[STATUS_W +: DATA_W]);
            mismatches++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_replies.push_back(serve_request(s_tdata_i[REQ_W-1:0],
                                                 s_tdata_i[REQ_W +: BOX_ID_W],
                                                 s_tdata_i[REQ_W+BOX_ID_W +: MSG_W]));
      end
      pending_o <= expected_replies.size();
    end
  end

endmodule

// ===== sim/tb_mailbox_queue_store.sv =====
// Top of the mailbox queue store testbench: clock, reset, request stimulus,
// receiver back-pressure and the verdict.
// Depends on mbq_pkg, mailbox_queue_store and mbq_checker.
module tb_mailbox_queue_store;
  import mbq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 630;
  localparam int POOL_SIZE      = 6;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int fail_count;
  int pending;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int stall_cycles = 0;
  bit hold_armed   = 1'b0;

  always #1 clk = ~clk;

  mailbox_queue_store dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mbq_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Offers one request and returns at the edge where it is accepted.
  task automatic push_req(input logic [REQ_W-1:0] req, input logic [BOX_ID_W-1:0] box,
                          input logic [MSG_W-1:0] word);
    logic [IN_TDATA_W-1:0] t;
    t                            = '0;
    t[REQ_W-1:0]                 = req;
    t[REQ_W +: BOX_ID_W]         = box;
    t[REQ_W+BOX_ID_W +: MSG_W]   = word;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Receiver: random stalls, plus one long hold so that the block backs up.
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_taken) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_taken = 1'b1;
      end
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_mailbox_queue_store NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [BOX_ID_W-1:0] pool [POOL_SIZE];
    logic [BOX_ID_W-1:0] box;
    logic [REQ_W-1:0]    req;
    logic [MSG_W-1:0]    word;
    int                  pick;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: a full queued box at the top index, mode flips on a
    // registered box, overwrite and non-popping reads in unqueued mode, and
    // traffic to boxes that were never registered.
    tx_idle_pct  = 6;
    rx_stall_pct = 49;
    push_req(REQ_REG_QUEUED,   10'd1023, {$urandom, $urandom});
    push_req(REQ_SEND,         10'd1023, 64'hFFFF_FFFF_FFFF_FFFF);
    push_req(REQ_SEND,         10'd1023, 64'h0);
    push_req(REQ_SEND,         10'd1023, 64'hA5A5_5A5A_C3C3_3C3C);
    push_req(REQ_SEND,         10'd1023, 64'h1111_2222_3333_4444);
    push_req(REQ_REG_UNQUEUED, 10'd1023, {$urandom, $urandom});
    push_req(REQ_SEND,         10'd1023, 64'h5555_6666_7777_8888);
    push_req(REQ_RECV,         10'd1023, {$urandom, $urandom});
    push_req(REQ_REG_QUEUED,   10'd1023, {$urandom, $urandom});
    push_req(REQ_RECV,         10'd1023, {$urandom, $urandom});
    push_req(REQ_RECV,         10'd1023, {$urandom, $urandom});
    push_req(REQ_RECV,         10'd1023, {$urandom, $urandom});
    push_req(REQ_RECV,         10'd1023, {$urandom, $urandom});
    push_req(REQ_REG_UNQUEUED, 10'd0,    {$urandom, $urandom});
    push_req(REQ_REG_UNQUEUED, 10'd0,    {$urandom, $urandom});
    push_req(REQ_SEND,         10'd0,    64'h8000_0000_0000_0001);
    push_req(REQ_SEND,         10'd0,    64'h0123_4567_89AB_CDEF);
    push_req(REQ_RECV,         10'd0,    {$urandom, $urandom});
    push_req(REQ_RECV,         10'd0,    {$urandom, $urandom});
    push_req(REQ_SEND,         10'd682,  64'h7FFF_FFFF_FFFF_FFFE);
    push_req(REQ_RECV,         10'd682,  {$urandom, $urandom});
    push_req(REQ_RECV,         10'd341,  {$urandom, $urandom});
    drain();

    // Random part: mostly a small pool of boxes so that queues fill, flip
    // mode and empty again; the rest spread over the whole index range.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct  = 6;
          rx_stall_pct = 49;
        end
        1: begin
          tx_idle_pct  = 49;
          rx_stall_pct = 6;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      foreach (pool[i]) pool[i] = BOX_ID_W'($urandom_range(0, NUM_BOXES - 1));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 0 && i == 100) hold_armed = 1'b1;
        if ($urandom_range(99) < 85) begin
          box = pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          box = BOX_ID_W'($urandom_range(0, NUM_BOXES - 1));
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
          req = REQ_REG_QUEUED;
        end else if (pick < 20) begin
          req = REQ_REG_UNQUEUED;
        end else if (pick < 60) begin
          req = REQ_SEND;
        end else begin
          req = REQ_RECV;
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
          word = '1;
        end else if (pick < 20) begin
          word = '0;
        end else begin
          word = {$urandom, $urandom};
        end
        push_req(req, box, word);
      end
      drain();
    end

    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_mailbox_queue_store OK");
    end else begin
      $display("tb_mailbox_queue_store NOT OK");
    end
    $finish;
  end

endmodule
